>>> src/wds_pkg.sv
// Shared types, constants and arithmetic helpers for the 2-D Wilson-Dirac stencil core.
// No dependencies; every other file in src uses this package by scoped names.
`default_nettype none
package wds_pkg;

  localparam int SITE_W      = 10;
  localparam int DATA_W      = 16;
  localparam int RES_W       = 20;
  localparam int STORE_DEPTH = 1024;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BARE_MASS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_WRAP_NEGATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_T_WRAP_NEGATE = 2'd2;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic signed [RES_W-1:0] RES_MAX = 20'sd524287;
  localparam logic signed [RES_W-1:0] RES_MIN = -20'sd524288;

  // Complex operand after one add or subtract of Q3.12 lanes.
  typedef struct packed {
    logic signed [16:0] re;
    logic signed [16:0] im;
  } opnd_t;

  // Exact complex product, 24 fractional bits, one guard bit for negation.
  typedef struct packed {
    logic signed [35:0] re;
    logic signed [35:0] im;
  } prod_t;

  typedef struct packed {
    logic signed [RES_W-1:0] val;
    logic                    clip;
  } res_t;

  function automatic prod_t cmul(opnd_t a, opnd_t b);
    logic signed [35:0] ar, ai, br, bi;
    prod_t p;
    ar = 36'(a.re);
    ai = 36'(a.im);
    br = 36'(b.re);
    bi = 36'(b.im);
    p.re = ar * br - ai * bi;
    p.im = ar * bi + ai * br;
    return p;
  endfunction

  function automatic prod_t cneg(prod_t a, logic neg);
    prod_t p;
    p.re = neg ? -a.re : a.re;
    p.im = neg ? -a.im : a.im;
    return p;
  endfunction

  // Round 2*D (24 fractional bits) to Q.12, half toward plus infinity, then clip.
  function automatic res_t finish(logic signed [40:0] acc);
    logic signed [41:0] sum;
    logic signed [28:0] r;
    res_t o;
    sum = 42'(acc) + 42'sd4096;
    r = 29'(sum >>> 13);
    o.clip = 1'b0;
    if (r > 29'(RES_MAX)) begin
      o.val  = RES_MAX;
      o.clip = 1'b1;
    end else if (r < 29'(RES_MIN)) begin
      o.val  = RES_MIN;
      o.clip = 1'b1;
    end else begin
      o.val = r[RES_W-1:0];
    end
    return o;
  endfunction

endpackage
`default_nettype wire

>>> src/wds_ifs.sv
// Valid/ready channel interfaces for the stencil core: input words and result words.
// Depends on wds_pkg for field widths.
`default_nettype none
interface wds_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  opcode;
  logic [wds_pkg::SITE_W-1:0]            site;
  logic signed [wds_pkg::DATA_W-1:0]     spin_up_re;
  logic signed [wds_pkg::DATA_W-1:0]     spin_up_im;
  logic signed [wds_pkg::DATA_W-1:0]     spin_dn_re;
  logic signed [wds_pkg::DATA_W-1:0]     spin_dn_im;
  logic signed [wds_pkg::DATA_W-1:0]     link_x_re;
  logic signed [wds_pkg::DATA_W-1:0]     link_x_im;
  logic signed [wds_pkg::DATA_W-1:0]     link_t_re;
  logic signed [wds_pkg::DATA_W-1:0]     link_t_im;
  modport source(output valid, opcode, site, spin_up_re, spin_up_im, spin_dn_re, spin_dn_im,
                 link_x_re, link_x_im, link_t_re, link_t_im, input ready);
  modport sink(input valid, opcode, site, spin_up_re, spin_up_im, spin_dn_re, spin_dn_im,
               link_x_re, link_x_im, link_t_re, link_t_im, output ready);
endinterface

interface wds_out_if;
  logic                              valid;
  logic                              ready;
  logic [wds_pkg::SITE_W-1:0]        out_site;
  logic signed [wds_pkg::RES_W-1:0]  res_up_re;
  logic signed [wds_pkg::RES_W-1:0]  res_up_im;
  logic signed [wds_pkg::RES_W-1:0]  res_dn_re;
  logic signed [wds_pkg::RES_W-1:0]  res_dn_im;
  logic                              saturated;
  modport source(output valid, out_site, res_up_re, res_up_im, res_dn_re, res_dn_im,
                 saturated, input ready);
  modport sink(input valid, out_site, res_up_re, res_up_im, res_dn_re, res_dn_im,
               saturated, output ready);
endinterface
`default_nettype wire

>>> src/wilson_dirac_stencil_2d_core.sv
// Top level of the 2-D Wilson-Dirac stencil core (uses wds_pkg and the wds_ifs interfaces).
// A compute word passes through the stage registers and then the output register.
// Throughput: one word per cycle; the pipeline moves as one and stalls only when the
// output register holds a word that is not taken. Replicated site stores give each
// compute its five spinor reads and three link reads at once.
// Reset (rst, synchronous) clears valid bits, resets the config registers, not the site stores.
`default_nettype none
module wilson_dirac_stencil_2d_core #(
  parameter int LX = 32,
  parameter int LT = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [wds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [wds_pkg::DATA_W-1:0]         cfg_data,
  wds_in_if.sink                                  in_ch,
  wds_out_if.source                               out_ch
);

  // Site index split x = site / LT by a reciprocal that is exact for any 10-bit site
  // as long as LT is at most 256; t is the remainder.
  localparam int RECIP    = (1 << 20) / LT + 1;
  localparam int LAST_ROW = ((LX - 1) * LT) % wds_pkg::STORE_DEPTH;
  localparam int AW       = wds_pkg::SITE_W;
  localparam int N_SPIN   = 5;
  localparam int N_LINK   = 3;

  // Configuration registers, to be written only while the core is idle; the core leaves that to the user.
  logic signed [15:0] bare_mass;
  logic               x_wrap_negate;
  logic               t_wrap_negate;

  always_ff @(posedge clk) begin
    if (rst) begin
      bare_mass     <= '0;
      x_wrap_negate <= 1'b0;
      t_wrap_negate <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        wds_pkg::REG_BARE_MASS:     bare_mass     <= cfg_data;
        wds_pkg::REG_X_WRAP_NEGATE: x_wrap_negate <= cfg_data[0];
        wds_pkg::REG_T_WRAP_NEGATE: t_wrap_negate <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together whenever the output register can take a word.
  logic adv;
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------- Stage 1: quotient x ----------------
  logic          s1_vld, s1_op;
  logic [AW-1:0] s1_site, s1_x;
  logic [63:0]   s1_spin, s1_link;
  logic [29:0]   quo;

  assign quo = 30'(in_ch.site) * 30'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else if (adv) s1_vld <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op   <= in_ch.opcode;
      s1_site <= in_ch.site;
      s1_x    <= quo[29:20];
      s1_spin <= {in_ch.spin_dn_im, in_ch.spin_dn_re, in_ch.spin_up_im, in_ch.spin_up_re};
      s1_link <= {in_ch.link_t_im, in_ch.link_t_re, in_ch.link_x_im, in_ch.link_x_re};
    end
  end

  // ---------------- Stage 2: remainder t, x boundary flags ----------------
  // A compute outside the lattice is dropped here; loads always go on.
  logic          s2_vld, s2_op, s2_x_last, s2_x_first;
  logic [AW-1:0] s2_site, s2_t;
  logic [63:0]   s2_spin, s2_link;
  logic [17:0]   xlt;
  logic          s1_keep;

  assign xlt     = 18'(s1_x) * 18'(LT);
  assign s1_keep = s1_vld && (s1_op == wds_pkg::OP_LOAD || 32'(s1_x) < LX);

  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else if (adv) s2_vld <= s1_keep;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op      <= s1_op;
      s2_site    <= s1_site;
      s2_t       <= s1_site - xlt[AW-1:0];
      s2_x_last  <= 32'(s1_x) == LX - 1;
      s2_x_first <= s1_x == '0;
      s2_spin    <= s1_spin;
      s2_link    <= s1_link;
    end
  end

  // ---------------- Stage 3: neighbour addresses and hop signs ----------------
  // All addresses are kept modulo the store depth, so large lattices alias entries.
  logic          s3_vld, s3_op;
  logic          s3_sr0, s3_sl0, s3_sr1, s3_sl1;
  logic [AW-1:0] s3_site, s3_nr0, s3_nr1, s3_nl0, s3_nl1;
  logic [63:0]   s3_spin, s3_link;
  logic          t_last, t_first;

  assign t_last  = 32'(s2_t) == LT - 1;
  assign t_first = s2_t == '0;

  always_ff @(posedge clk) begin
    if (rst) s3_vld <= 1'b0;
    else if (adv) s3_vld <= s2_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_op   <= s2_op;
      s3_site <= s2_site;
      s3_nr0  <= s2_x_last  ? s2_t : s2_site + AW'(LT);
      s3_nl0  <= s2_x_first ? AW'(LAST_ROW) + s2_t : s2_site - AW'(LT);
      s3_nr1  <= t_last  ? s2_site - s2_t : s2_site + AW'(1);
      s3_nl1  <= t_first ? s2_site + AW'(LT - 1) : s2_site - AW'(1);
      s3_sr0  <= s2_x_last  && x_wrap_negate;
      s3_sl0  <= s2_x_first && x_wrap_negate;
      s3_sr1  <= t_last  && t_wrap_negate;
      s3_sl1  <= t_first && t_wrap_negate;
      s3_spin <= s2_spin;
      s3_link <= s2_link;
    end
  end

  // ---------------- Site stores ----------------
  // Each read port has its own copy of the store; loads write all copies at once.
  // Writes and reads happen at the same edge, in word order, so a compute sees every
  // load accepted before it and none accepted after it.
  logic          st_we;
  logic [AW-1:0] spin_addr [N_SPIN];
  logic [AW-1:0] link_addr [N_LINK];
  logic [63:0]   spin_rd   [N_SPIN];
  logic [63:0]   link_rd   [N_LINK];

  assign st_we = adv && s3_vld && s3_op == wds_pkg::OP_LOAD;
  assign spin_addr[0] = s3_site;
  assign spin_addr[1] = s3_nr0;
  assign spin_addr[2] = s3_nr1;
  assign spin_addr[3] = s3_nl0;
  assign spin_addr[4] = s3_nl1;
  assign link_addr[0] = s3_site;
  assign link_addr[1] = s3_nl0;
  assign link_addr[2] = s3_nl1;

  for (genvar k = 0; k < N_SPIN; k++) begin : g_spin
    logic [63:0] mem [wds_pkg::STORE_DEPTH];
    always_ff @(posedge clk) begin
      if (st_we) mem[s3_site] <= s3_spin;
      if (adv) spin_rd[k] <= mem[spin_addr[k]];
    end
  end

  for (genvar k = 0; k < N_LINK; k++) begin : g_link
    logic [63:0] mem [wds_pkg::STORE_DEPTH];
    always_ff @(posedge clk) begin
      if (st_we) mem[s3_site] <= s3_link;
      if (adv) link_rd[k] <= mem[link_addr[k]];
    end
  end

  // ---------------- Stage 4: read data ----------------
  logic          s4_vld, s4_sr0, s4_sl0, s4_sr1, s4_sl1;
  logic [AW-1:0] s4_site;

  always_ff @(posedge clk) begin
    if (rst) s4_vld <= 1'b0;
    else if (adv) s4_vld <= s3_vld && s3_op == wds_pkg::OP_COMPUTE;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_site <= s3_site;
      s4_sr0  <= s3_sr0;
      s4_sl0  <= s3_sl0;
      s4_sr1  <= s3_sr1;
      s4_sl1  <= s3_sl1;
    end
  end

  // Lanes of the read words, sign-extended to 17 bits.
  logic signed [16:0] a_re, a_im, b_re, b_im, c_re, c_im, d_re, d_im;
  logic signed [16:0] e_re, e_im, f_re, f_im, g_re, g_im, h_re, h_im;
  wds_pkg::opnd_t     u0, u1, v0, v1;

  assign a_re = 17'($signed(spin_rd[1][15:0]));
  assign a_im = 17'($signed(spin_rd[1][31:16]));
  assign b_re = 17'($signed(spin_rd[1][47:32]));
  assign b_im = 17'($signed(spin_rd[1][63:48]));
  assign c_re = 17'($signed(spin_rd[2][15:0]));
  assign c_im = 17'($signed(spin_rd[2][31:16]));
  assign d_re = 17'($signed(spin_rd[2][47:32]));
  assign d_im = 17'($signed(spin_rd[2][63:48]));
  assign e_re = 17'($signed(spin_rd[3][15:0]));
  assign e_im = 17'($signed(spin_rd[3][31:16]));
  assign f_re = 17'($signed(spin_rd[3][47:32]));
  assign f_im = 17'($signed(spin_rd[3][63:48]));
  assign g_re = 17'($signed(spin_rd[4][15:0]));
  assign g_im = 17'($signed(spin_rd[4][31:16]));
  assign h_re = 17'($signed(spin_rd[4][47:32]));
  assign h_im = 17'($signed(spin_rd[4][63:48]));

  // Own links for forward hops; conjugated neighbour links for backward hops.
  assign u0.re = 17'($signed(link_rd[0][15:0]));
  assign u0.im = 17'($signed(link_rd[0][31:16]));
  assign u1.re = 17'($signed(link_rd[0][47:32]));
  assign u1.im = 17'($signed(link_rd[0][63:48]));
  assign v0.re = 17'($signed(link_rd[1][15:0]));
  assign v0.im = -17'($signed(link_rd[1][31:16]));
  assign v1.re = 17'($signed(link_rd[2][47:32]));
  assign v1.im = -17'($signed(link_rd[2][63:48]));

  // ---------------- Stage 5: spin projections ----------------
  logic           s5_vld, s5_sr0, s5_sl0, s5_sr1, s5_sl1;
  logic [AW-1:0]  s5_site;
  wds_pkg::opnd_t s5_u0, s5_u1, s5_v0, s5_v1;
  wds_pkg::opnd_t s5_p1, s5_p2, s5_p3, s5_p4, s5_p5, s5_p6;
  logic [63:0]    s5_phi;

  always_ff @(posedge clk) begin
    if (rst) s5_vld <= 1'b0;
    else if (adv) s5_vld <= s4_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_site  <= s4_site;
      s5_sr0   <= s4_sr0;
      s5_sl0   <= s4_sl0;
      s5_sr1   <= s4_sr1;
      s5_sl1   <= s4_sl1;
      s5_u0    <= u0;
      s5_u1    <= u1;
      s5_v0    <= v0;
      s5_v1    <= v1;
      s5_phi   <= spin_rd[0];
      s5_p1.re <= a_re - b_re;     // a - b
      s5_p1.im <= a_im - b_im;
      s5_p2.re <= c_re - d_im;     // c + i d
      s5_p2.im <= c_im + d_re;
      s5_p3.re <= e_re + f_re;     // e + f
      s5_p3.im <= e_im + f_im;
      s5_p4.re <= g_re + h_im;     // g - i h
      s5_p4.im <= g_im - h_re;
      s5_p5.re <= d_re + c_im;     // d - i c
      s5_p5.im <= d_im - c_re;
      s5_p6.re <= h_re - g_im;     // h + i g
      s5_p6.im <= h_im + g_re;
    end
  end

  // ---------------- Stage 6: link products and mass terms ----------------
  logic               s6_vld, s6_sr0, s6_sl0, s6_sr1, s6_sl1;
  logic [AW-1:0]      s6_site;
  wds_pkg::prod_t     s6_m1, s6_m2, s6_m3, s6_m4, s6_m5, s6_m6;
  logic signed [33:0] s6_mu_re, s6_mu_im, s6_md_re, s6_md_im;
  logic signed [33:0] mass;

  // Twice (m0 + 2) in Q.12.
  assign mass = (34'(bare_mass) + 34'sd8192) <<< 1;

  always_ff @(posedge clk) begin
    if (rst) s6_vld <= 1'b0;
    else if (adv) s6_vld <= s5_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_site  <= s5_site;
      s6_sr0   <= s5_sr0;
      s6_sl0   <= s5_sl0;
      s6_sr1   <= s5_sr1;
      s6_sl1   <= s5_sl1;
      s6_m1    <= wds_pkg::cmul(s5_u0, s5_p1);
      s6_m2    <= wds_pkg::cmul(s5_u1, s5_p2);
      s6_m3    <= wds_pkg::cmul(s5_v0, s5_p3);
      s6_m4    <= wds_pkg::cmul(s5_v1, s5_p4);
      s6_m5    <= wds_pkg::cmul(s5_u1, s5_p5);
      s6_m6    <= wds_pkg::cmul(s5_v1, s5_p6);
      s6_mu_re <= mass * 34'($signed(s5_phi[15:0]));
      s6_mu_im <= mass * 34'($signed(s5_phi[31:16]));
      s6_md_re <= mass * 34'($signed(s5_phi[47:32]));
      s6_md_im <= mass * 34'($signed(s5_phi[63:48]));
    end
  end

  // ---------------- Stage 7: hopping sums and accumulation of 2*D ----------------
  logic               s7_vld;
  logic [AW-1:0]      s7_site;
  logic signed [40:0] s7_acc_ur, s7_acc_ui, s7_acc_dr, s7_acc_di;
  wds_pkg::prod_t     t1, t2, t3, t4, w2, w4, nt1;
  logic signed [40:0] hu_re, hu_im, hd_re, hd_im;

  assign t1  = wds_pkg::cneg(s6_m1, s6_sr0);
  assign t2  = wds_pkg::cneg(s6_m2, s6_sr1);
  assign t3  = wds_pkg::cneg(s6_m3, s6_sl0);
  assign t4  = wds_pkg::cneg(s6_m4, s6_sl1);
  assign w2  = wds_pkg::cneg(s6_m5, s6_sr1);
  assign w4  = wds_pkg::cneg(s6_m6, s6_sl1);
  assign nt1 = wds_pkg::cneg(t1, 1'b1);

  assign hu_re = 41'(t1.re) + 41'(t2.re) + 41'(t3.re) + 41'(t4.re);
  assign hu_im = 41'(t1.im) + 41'(t2.im) + 41'(t3.im) + 41'(t4.im);
  assign hd_re = 41'(nt1.re) + 41'(w2.re) + 41'(t3.re) + 41'(w4.re);
  assign hd_im = 41'(nt1.im) + 41'(w2.im) + 41'(t3.im) + 41'(w4.im);

  always_ff @(posedge clk) begin
    if (rst) s7_vld <= 1'b0;
    else if (adv) s7_vld <= s6_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_site   <= s6_site;
      s7_acc_ur <= 41'(s6_mu_re) - hu_re;
      s7_acc_ui <= 41'(s6_mu_im) - hu_im;
      s7_acc_dr <= 41'(s6_md_re) - hd_re;
      s7_acc_di <= 41'(s6_md_im) - hd_im;
    end
  end

  // ---------------- Output register: rounding and saturation ----------------
  wds_pkg::res_t r_ur, r_ui, r_dr, r_di;

  assign r_ur = wds_pkg::finish(s7_acc_ur);
  assign r_ui = wds_pkg::finish(s7_acc_ui);
  assign r_dr = wds_pkg::finish(s7_acc_dr);
  assign r_di = wds_pkg::finish(s7_acc_di);

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (adv) out_ch.valid <= s7_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.out_site  <= s7_site;
      out_ch.res_up_re <= r_ur.val;
      out_ch.res_up_im <= r_ui.val;
      out_ch.res_dn_re <= r_dr.val;
      out_ch.res_dn_im <= r_di.val;
      out_ch.saturated <= r_ur.clip | r_ui.clip | r_dr.clip | r_di.clip;
    end
  end

endmodule
`default_nettype wire

>>> sim/wds_checker.sv
// Scoreboard for the stencil core: tracks site stores and registers, predicts every in-lattice
// compute word and compares it with the result channel. Depends on wds_pkg and wds_ifs.
module wds_checker #(
  parameter int LX = 32,
  parameter int LT = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [wds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wds_pkg::DATA_W-1:0]    cfg_data,
  wds_in_if                             in_ch,
  wds_out_if                            out_ch,
  output int                            fails,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    longint re;
    longint im;
  } cpx_t;

  typedef struct {
    logic [wds_pkg::SITE_W-1:0] site;
    logic [wds_pkg::RES_W-1:0]  up_re, up_im, dn_re, dn_im;
    logic                       sat;
  } dirac_word_t;

  logic [63:0] spinor_mem [wds_pkg::STORE_DEPTH];
  logic [63:0] link_mem [wds_pkg::STORE_DEPTH];
  logic [15:0] mass_q12;
  logic        x_neg, t_neg;
  dirac_word_t dirac_q[$];

  function automatic cpx_t lane_of(logic [63:0] w, int k);
    cpx_t c;
    c.re = longint'($signed(w[32*k +: 16]));
    c.im = longint'($signed(w[32*k+16 +: 16]));
    return c;
  endfunction

  function automatic cpx_t c_add(cpx_t a, cpx_t b);
    cpx_t c;
    c.re = a.re + b.re;
    c.im = a.im + b.im;
    return c;
  endfunction

  function automatic cpx_t c_sub(cpx_t a, cpx_t b);
    cpx_t c;
    c.re = a.re - b.re;
    c.im = a.im - b.im;
    return c;
  endfunction

  function automatic cpx_t c_muli(cpx_t a);
    cpx_t c;
    c.re = -a.im;
    c.im = a.re;
    return c;
  endfunction

  function automatic cpx_t c_conj(cpx_t a);
    a.im = -a.im;
    return a;
  endfunction

  function automatic cpx_t c_mul(cpx_t a, cpx_t b);
    cpx_t c;
    c.re = a.re * b.re - a.im * b.im;
    c.im = a.re * b.im + a.im * b.re;
    return c;
  endfunction

  function automatic cpx_t c_sign(cpx_t a, bit neg);
    if (neg) begin
      a.re = -a.re;
      a.im = -a.im;
    end
    return a;
  endfunction

  // Rounds doubled 24-bit fraction sums to Q7.12, half up, and clips.
  function automatic logic [19:0] round_clip(longint acc, ref bit sat);
    longint r;
    r = (acc + 4096) >>> 13;
    if (r > 524287) begin
      r = 524287;
      sat = 1;
    end else if (r < -524288) begin
      r = -524288;
      sat = 1;
    end
    return r[19:0];
  endfunction

  function automatic dirac_word_t apply_dirac(int unsigned s);
    int unsigned x, t, xr, xl, tr, tl, nr0, nr1, nl0, nl1;
    bit sr0, sr1, sl0, sl1, sat;
    cpx_t u0, u1, v0, v1, a, b, c, d, e, f, g, h, pu, pd, t1, t2, t3, t4, w2, w4, hu, hd;
    longint m2;
    dirac_word_t o;
    x = s / LT;
    t = s % LT;
    xr = (x + 1 == LX) ? 0 : x + 1;
    xl = (x == 0) ? LX - 1 : x - 1;
    tr = (t + 1 == LT) ? 0 : t + 1;
    tl = (t == 0) ? LT - 1 : t - 1;
    nr0 = (xr * LT + t) % 1024;
    nr1 = (x * LT + tr) % 1024;
    nl0 = (xl * LT + t) % 1024;
    nl1 = (x * LT + tl) % 1024;
    sr0 = (x + 1 == LX) && x_neg;
    sl0 = (x == 0) && x_neg;
    sr1 = (t + 1 == LT) && t_neg;
    sl1 = (t == 0) && t_neg;
    u0 = lane_of(link_mem[s], 0);
    u1 = lane_of(link_mem[s], 1);
    v0 = c_conj(lane_of(link_mem[nl0], 0));
    v1 = c_conj(lane_of(link_mem[nl1], 1));
    a = lane_of(spinor_mem[nr0], 0);
    b = lane_of(spinor_mem[nr0], 1);
    c = lane_of(spinor_mem[nr1], 0);
    d = lane_of(spinor_mem[nr1], 1);
    e = lane_of(spinor_mem[nl0], 0);
    f = lane_of(spinor_mem[nl0], 1);
    g = lane_of(spinor_mem[nl1], 0);
    h = lane_of(spinor_mem[nl1], 1);
    pu = lane_of(spinor_mem[s], 0);
    pd = lane_of(spinor_mem[s], 1);
    t1 = c_sign(c_mul(u0, c_sub(a, b)), sr0);
    t2 = c_sign(c_mul(u1, c_add(c, c_muli(d))), sr1);
    t3 = c_sign(c_mul(v0, c_add(e, f)), sl0);
    t4 = c_sign(c_mul(v1, c_sub(g, c_muli(h))), sl1);
    hu = c_add(c_add(t1, t2), c_add(t3, t4));
    w2 = c_sign(c_mul(u1, c_sub(d, c_muli(c))), sr1);
    w4 = c_sign(c_mul(v1, c_add(h, c_muli(g))), sl1);
    hd = c_add(c_add(c_sign(t1, 1), w2), c_add(t3, w4));
    m2 = 2 * (longint'($signed(mass_q12)) + 8192);
    sat = 0;
    o.site = s[9:0];
    o.up_re = round_clip(m2 * pu.re - hu.re, sat);
    o.up_im = round_clip(m2 * pu.im - hu.im, sat);
    o.dn_re = round_clip(m2 * pd.re - hd.re, sat);
    o.dn_im = round_clip(m2 * pd.im - hd.im, sat);
    o.sat = sat;
    return o;
  endfunction

  assign pending = dirac_q.size();

  always @(posedge clk) begin
    dirac_word_t want;
    if (rst) begin
      mass_q12 <= '0;
      x_neg <= 1'b0;
      t_neg <= 1'b1;
      fails <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wds_pkg::REG_BARE_MASS:     mass_q12 <= cfg_data;
          wds_pkg::REG_X_WRAP_NEGATE: x_neg <= cfg_data[0];
          wds_pkg::REG_T_WRAP_NEGATE: t_neg <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.opcode == wds_pkg::OP_LOAD) begin
          spinor_mem[in_ch.site] <= {in_ch.spin_dn_im, in_ch.spin_dn_re,
                                     in_ch.spin_up_im, in_ch.spin_up_re};
          link_mem[in_ch.site] <= {in_ch.link_t_im, in_ch.link_t_re,
                                   in_ch.link_x_im, in_ch.link_x_re};
        end else if (in_ch.site / LT < LX) begin
          dirac_q.push_back(apply_dirac(in_ch.site));
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (dirac_q.size() == 0) begin
          if (fails < 10)
            $display("unexpected result word at site %0d", out_ch.out_site);
          fails <= fails + 1;
        end else begin
          want = dirac_q.pop_front();
          if (want.site !== out_ch.out_site || want.up_re !== out_ch.res_up_re ||
              want.up_im !== out_ch.res_up_im || want.dn_re !== out_ch.res_dn_re ||
              want.dn_im !== out_ch.res_dn_im || want.sat !== out_ch.saturated) begin
            if (fails < 10)
              $display("mismatch: expected site %0d %h %h %h %h sat %b, got %0d %h %h %h %h sat %b",
                       want.site, want.up_re, want.up_im, want.dn_re, want.dn_im, want.sat,
                       out_ch.out_site, out_ch.res_up_re, out_ch.res_up_im,
                       out_ch.res_dn_re, out_ch.res_dn_im, out_ch.saturated);
            fails <= fails + 1;
          end
        end
      end
    end
  end
endmodule

>>> sim/testbench.sv
// Top of the stencil core testbench: clock, reset, register writes and stimulus words.
// Depends on wds_pkg, wds_ifs, the core itself and the wds_checker scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LX = 32;
  localparam int LT = 32;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [wds_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [wds_pkg::DATA_W-1:0] cfg_data = '0;
  int fails, pending;

  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  // Sites whose stores have been written; random computes only touch written neighborhoods.
  bit loaded [1024];

  wds_in_if in_ch();
  wds_out_if out_ch();

  always #1 clk = ~clk;

  wilson_dirac_stencil_2d_core #(.LX(LX), .LT(LT)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  wds_checker #(.LX(LX), .LT(LT)) scoreboard (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch), .fails(fails), .pending(pending)
  );

  // The receiver drives ready from random draws that favour high, and once holds it low
  // so that the pipeline backs up.
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    if (hold_go && !hold_done && hold_left == 0) begin
      hold_left <= 400;
      hold_done <= 1'b1;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      hold_left <= 0;
      if (($urandom_range(0, 1023) / 128) % 2 == 0)
        out_ch.ready <= 1'b1;
      else
        out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = wds_pkg::OP_LOAD;
    in_ch.site = '0;
    in_ch.spin_up_re = '0;
    in_ch.spin_up_im = '0;
    in_ch.spin_dn_re = '0;
    in_ch.spin_dn_im = '0;
    in_ch.link_x_re = '0;
    in_ch.link_x_im = '0;
    in_ch.link_t_re = '0;
    in_ch.link_t_im = '0;
  end

  function automatic logic [15:0] pick_q12();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h1000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int site_of(int x, int t);
    return ((x + LX) % LX) * LT + (t + LT) % LT;
  endfunction

  function automatic bit stencil_ready(int s);
    int x, t;
    x = s / LT;
    t = s % LT;
    return loaded[s] && loaded[site_of(x + 1, t)] && loaded[site_of(x - 1, t)] &&
           loaded[site_of(x, t + 1)] && loaded[site_of(x, t - 1)];
  endfunction

  // Offers one word and holds it until the core takes it; ready is sampled at the
  // falling edge, where it is settled for the coming rising edge.
  task automatic push_word(logic op, int s, logic [15:0] v [8]);
    bit took;
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.site <= s[9:0];
    in_ch.spin_up_re <= v[0];
    in_ch.spin_up_im <= v[1];
    in_ch.spin_dn_re <= v[2];
    in_ch.spin_dn_im <= v[3];
    in_ch.link_x_re <= v[4];
    in_ch.link_x_im <= v[5];
    in_ch.link_t_re <= v[6];
    in_ch.link_t_im <= v[7];
    do begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end while (!took);
    if (op == wds_pkg::OP_LOAD)
      loaded[s] = 1'b1;
  endtask

  task automatic load_site(int s, bit extreme);
    logic [15:0] v [8];
    foreach (v[i])
      v[i] = extreme ? (s[0] ? 16'h8000 : 16'h7fff) : pick_q12();
    push_word(wds_pkg::OP_LOAD, s, v);
  endtask

  task automatic compute_site(int s);
    logic [15:0] v [8];
    // Payload lanes are ignored on a compute, so random junk rides along.
    foreach (v[i])
      v[i] = 16'($urandom);
    push_word(wds_pkg::OP_COMPUTE, s, v);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Registers change only with the core drained and its pipeline flushed.
  // cfg_we drops after each write, so back-to-back writes stay apart.
  task automatic write_reg(logic [wds_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    idle_gap(1);
    while (pending != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Random words: mostly loads around the x wrap and computes at sites whose whole
  // stencil is written, so wrap handling in both directions gets exercised often.
  task automatic random_words(int count, bit flood);
    int burst, s, tries;
    burst = 0;
    for (int k = 0; k < count; k++) begin
      if (burst == 0) begin
        idle_gap(flood ? 0 : $urandom_range(0, 8));
        burst = $urandom_range(1, 20);
      end
      burst--;
      s = -1;
      if ($urandom_range(0, 1) == 1) begin
        for (tries = 0; tries < 20 && s < 0; tries++) begin
          s = site_of($urandom_range(0, 2) - 1, $urandom_range(0, LT - 1));
          if (!stencil_ready(s))
            s = -1;
        end
      end
      if (s >= 0)
        compute_site(s);
      else if ($urandom_range(0, 9) < 7)
        load_site(site_of($urandom_range(0, 4) - 2, $urandom_range(0, LT - 1)), 1'b0);
      else
        load_site($urandom_range(0, 1023), 1'b0);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: the corner neighborhood around site 0 with full-scale values,
    // so the wrap in both directions and the range limits are hit first.
    for (int dx = -1; dx <= 1; dx++)
      for (int dt = -1; dt <= 1; dt++)
        load_site(site_of(dx, dt), 1'b1);
    load_site(site_of(LX - 1, LT - 2), 1'b1);
    load_site(site_of(LX - 2, LT - 1), 1'b1);
    compute_site(0);
    compute_site(site_of(LX - 1, LT - 1));
    compute_site(site_of(0, LT - 1));
    compute_site(site_of(LX - 1, 0));
    drain();
    write_reg(wds_pkg::REG_BARE_MASS, 16'h7fff);
    write_reg(wds_pkg::REG_X_WRAP_NEGATE, 16'd1);
    write_reg(wds_pkg::REG_T_WRAP_NEGATE, 16'd0);
    compute_site(0);
    compute_site(site_of(LX - 1, LT - 1));
    drain();
    write_reg(wds_pkg::REG_BARE_MASS, 16'h8000);
    compute_site(0);
    compute_site(site_of(0, LT - 1));
    drain();

    // Random phases, each under its own register setting, but for the flood after the first.
    random_words(200, 1'b0);
    // Flood while the receiver holds off, then wait for the backlog to clear.
    hold_go = 1'b1;
    random_words(60, 1'b1);
    drain();
    write_reg(wds_pkg::REG_BARE_MASS, 16'h7fff);
    write_reg(wds_pkg::REG_X_WRAP_NEGATE, 16'd0);
    write_reg(wds_pkg::REG_T_WRAP_NEGATE, 16'd1);
    random_words(200, 1'b0);
    drain();
    write_reg(wds_pkg::REG_BARE_MASS, 16'h8000);
    write_reg(wds_pkg::REG_X_WRAP_NEGATE, 16'd1);
    write_reg(wds_pkg::REG_T_WRAP_NEGATE, 16'd1);
    random_words(200, 1'b0);
    drain();
    write_reg(wds_pkg::REG_BARE_MASS, 16'($urandom));
    write_reg(wds_pkg::REG_X_WRAP_NEGATE, 16'd0);
    write_reg(wds_pkg::REG_T_WRAP_NEGATE, 16'd0);
    random_words(200, 1'b0);
    drain();
    write_reg(wds_pkg::REG_BARE_MASS, 16'd0);
    random_words(170, 1'b0);
    drain();

    if (fails == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end
endmodule
